FILE: design/mmdp_pkg.sv
// Shared types and constants for the matrix multiply dot-product block.
`timescale 1ns / 1ps

package mmdp_pkg;

    localparam int DIM_DEFAULT        = 16;
    localparam int ENTRY_BITS_DEFAULT = 16;

    localparam int ACC_BITS   = 40;
    localparam int VALUE_BITS = 16;
    localparam int INDEX_BITS = 4;
    localparam int SIZE_BITS  = 5;

    localparam logic [SIZE_BITS-1:0] SIZE_RESET = 5'd16;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_READ = 1'b1;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_RUN,
        SEQ_DRAIN
    } seq_state_t;

    typedef struct packed {
        logic issue;
        logic finish;
    } seq_ctrl_t;

endpackage

FILE: design/mmdp_store.sv
// Left and right matrix stores: one write port, one registered read port each.
`timescale 1ns / 1ps

module mmdp_store
    import mmdp_pkg::*;
#(
    parameter int DIM        = DIM_DEFAULT,
    parameter int ENTRY_BITS = ENTRY_BITS_DEFAULT,
    localparam int DEPTH     = DIM * DIM,
    localparam int ADDR_BITS = $clog2(DEPTH)
)
(
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [ADDR_BITS-1:0]         wr_addr,
    input  logic signed [ENTRY_BITS-1:0] wr_left,
    input  logic signed [ENTRY_BITS-1:0] wr_right,
    input  logic                         rd_en,
    input  logic [ADDR_BITS-1:0]         rd_left_addr,
    input  logic [ADDR_BITS-1:0]         rd_right_addr,
    output logic signed [ENTRY_BITS-1:0] rd_left,
    output logic signed [ENTRY_BITS-1:0] rd_right
);

    logic signed [ENTRY_BITS-1:0] left_mem  [DEPTH];
    logic signed [ENTRY_BITS-1:0] right_mem [DEPTH];
    logic signed [ENTRY_BITS-1:0] rd_left_reg;
    logic signed [ENTRY_BITS-1:0] rd_right_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            left_mem[wr_addr]  <= wr_left;
            right_mem[wr_addr] <= wr_right;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_left_reg  <= left_mem[rd_left_addr];
            rd_right_reg <= right_mem[rd_right_addr];
        end
    end

    assign rd_left  = rd_left_reg;
    assign rd_right = rd_right_reg;

endmodule

FILE: design/matrix_multiply_dot_product.sv
// Top level: matrix stores, read sequencer and multiply-accumulate datapath.
`timescale 1ns / 1ps
// Load request: written to both stores at the accepting edge if row and col are in range; busy stays low.
// Read request: n = min(size_in_use, DIM); RUN issues n store reads, then DRAIN waits for
//   the MAC pipeline to empty; done pulses as busy drops (RUN is skipped if n is 0 or out of range).
// One element pair per cycle from the single store read port; done strobes cannot be stalled.
// rst_n (async, active low) clears the sequencer, strobe and size_in_use (back to 16);
//   store contents are undefined until written and get no clearing pass.

module matrix_multiply_dot_product
    import mmdp_pkg::*;
#(
    parameter int DIM        = DIM_DEFAULT,
    parameter int ENTRY_BITS = ENTRY_BITS_DEFAULT
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration: size_in_use
    input  logic                         cfg_we,
    input  logic [SIZE_BITS-1:0]         cfg_data,
    // request channel
    input  logic                         start,
    output logic                         busy,
    input  logic                         action,
    input  logic [INDEX_BITS-1:0]        row,
    input  logic [INDEX_BITS-1:0]        col,
    input  logic signed [VALUE_BITS-1:0] left_value,
    input  logic signed [VALUE_BITS-1:0] right_value,
    // result channel
    output logic                         done,
    output logic signed [ACC_BITS-1:0]   product_value
);

    localparam int DEPTH     = DIM * DIM;
    localparam int ADDR_BITS = $clog2(DEPTH);
    localparam int IDX_BITS  = $clog2(DIM);
    localparam int PROD_BITS = 2 * ENTRY_BITS;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [SIZE_BITS-1:0] size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            size_reg <= SIZE_RESET;
        else if (cfg_we)
            size_reg <= cfg_data;
    end

    // Dot-product length, clamped to the array dimension.
    logic [SIZE_BITS-1:0] size_clamped;
    assign size_clamped = (32'(size_reg) > DIM) ? SIZE_BITS'(DIM) : size_reg;

    // ------------------------------------------------------------------
    // Request decode
    // ------------------------------------------------------------------
    logic accept;
    logic in_range;
    logic load_req;
    logic read_req;

    assign accept   = start && !busy;
    assign in_range = (32'(row) < DIM) && (32'(col) < DIM);
    assign load_req = accept && (action == ACT_LOAD);
    assign read_req = accept && (action == ACT_READ);

    // Load address: row * DIM + col. Index bits are widened or trimmed to the
    // dimension; out-of-range loads are dropped, so trimming never aliases.
    logic [IDX_BITS+INDEX_BITS-1:0] in_row_ext;
    logic [IDX_BITS+INDEX_BITS-1:0] in_col_ext;
    logic [ADDR_BITS-1:0]           wr_addr;

    assign in_row_ext = {{IDX_BITS{1'b0}}, row};
    assign in_col_ext = {{IDX_BITS{1'b0}}, col};
    assign wr_addr    = ADDR_BITS'(in_row_ext[IDX_BITS-1:0]) * ADDR_BITS'(DIM)
                      + ADDR_BITS'(in_col_ext[IDX_BITS-1:0]);

    // ------------------------------------------------------------------
    // Read sequencer
    // ------------------------------------------------------------------
    seq_state_t           state_reg, state_next;
    seq_ctrl_t            ctrl;
    logic [INDEX_BITS-1:0] row_reg, row_next;
    logic [INDEX_BITS-1:0] col_reg, col_next;
    logic [SIZE_BITS-1:0] n_reg, n_next;
    logic [SIZE_BITS-1:0] k_reg, k_next;
    logic                 last_issue;
    logic                 mem_valid_reg;
    logic                 prod_valid_reg;
    logic                 pipe_empty;

    assign last_issue = (k_reg == (n_reg - 1'b1));
    assign pipe_empty = !mem_valid_reg && !prod_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            SEQ_IDLE:
            begin
                if (read_req)
                begin
                    // empty sum or out of range: straight to the result
                    if (in_range && (size_clamped != '0))
                        state_next = SEQ_RUN;
                    else
                        state_next = SEQ_DRAIN;
                end
            end
            SEQ_RUN:
            begin
                if (last_issue)
                    state_next = SEQ_DRAIN;
            end
            SEQ_DRAIN:
            begin
                if (pipe_empty)
                    state_next = SEQ_IDLE;
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl = '0;
        case (state_reg)
            SEQ_IDLE:
            begin
                ctrl = '0;
            end
            SEQ_RUN:
            begin
                ctrl.issue = 1'b1;
            end
            SEQ_DRAIN:
            begin
                ctrl.finish = pipe_empty;
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

    assign busy = (state_reg != SEQ_IDLE);

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        n_next   = n_reg;
        k_next   = k_reg;
        if (read_req)
        begin
            row_next = row;
            col_next = col;
            n_next   = size_clamped;
            k_next   = '0;
        end
        else if (ctrl.issue)
        begin
            k_next = k_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= SEQ_IDLE;
            k_reg          <= '0;
            n_reg          <= '0;
            mem_valid_reg  <= 1'b0;
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            k_reg          <= k_next;
            n_reg          <= n_next;
            mem_valid_reg  <= ctrl.issue;
            prod_valid_reg <= mem_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg <= row_next;
        col_reg <= col_next;
    end

    // Read addresses: left[row][k] and right[k][col].
    logic [IDX_BITS+INDEX_BITS-1:0] row_ext;
    logic [IDX_BITS+INDEX_BITS-1:0] col_ext;
    logic [IDX_BITS+SIZE_BITS-1:0]  k_ext;
    logic [ADDR_BITS-1:0]           rd_left_addr;
    logic [ADDR_BITS-1:0]           rd_right_addr;

    assign row_ext = {{IDX_BITS{1'b0}}, row_reg};
    assign col_ext = {{IDX_BITS{1'b0}}, col_reg};
    assign k_ext   = {{IDX_BITS{1'b0}}, k_reg};

    assign rd_left_addr  = ADDR_BITS'(row_ext[IDX_BITS-1:0]) * ADDR_BITS'(DIM)
                         + ADDR_BITS'(k_ext[IDX_BITS-1:0]);
    assign rd_right_addr = ADDR_BITS'(k_ext[IDX_BITS-1:0]) * ADDR_BITS'(DIM)
                         + ADDR_BITS'(col_ext[IDX_BITS-1:0]);

    // ------------------------------------------------------------------
    // Stores. Loads are taken only while idle, so a write never overlaps
    // a read in flight: busy is the interlock.
    // ------------------------------------------------------------------
    logic signed [ENTRY_BITS-1:0] rd_left;
    logic signed [ENTRY_BITS-1:0] rd_right;

    mmdp_store #(
        .DIM        (DIM),
        .ENTRY_BITS (ENTRY_BITS)
    ) u_store (
        .clk           (clk),
        .wr_en         (load_req && in_range),
        .wr_addr       (wr_addr),
        .wr_left       (ENTRY_BITS'(left_value)),
        .wr_right      (ENTRY_BITS'(right_value)),
        .rd_en         (ctrl.issue),
        .rd_left_addr  (rd_left_addr),
        .rd_right_addr (rd_right_addr),
        .rd_left       (rd_left),
        .rd_right      (rd_right)
    );

    // ------------------------------------------------------------------
    // Multiply-accumulate: product registered, then added into the
    // 40-bit accumulator (wraps mod 2^40).
    // ------------------------------------------------------------------
    logic signed [PROD_BITS-1:0] prod_reg, prod_next;
    logic signed [ACC_BITS-1:0]  acc_reg, acc_next;

    assign prod_next = rd_left * rd_right;

    always_comb
    begin
        acc_next = acc_reg;
        if (read_req)
            acc_next = '0;
        else if (prod_valid_reg)
            acc_next = acc_reg + ACC_BITS'(prod_reg);
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    // ------------------------------------------------------------------
    // Result register: one-cycle strobe
    // ------------------------------------------------------------------
    logic                       done_reg;
    logic signed [ACC_BITS-1:0] product_value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= ctrl.finish;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.finish)
            product_value_reg <= acc_reg;
    end

    assign done          = done_reg;
    assign product_value = product_value_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_done_after_drain : assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == SEQ_DRAIN))
        else $error("result strobe without a finished drain");

    a_k_in_range : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SEQ_RUN) |-> (k_reg < n_reg))
        else $error("element index ran past the dot-product length");

    a_mem_follows_issue : assert property (@(posedge clk) disable iff (!rst_n)
        mem_valid_reg |-> $past(ctrl.issue))
        else $error("store data marked valid without a read issued");

    a_idle_pipe_empty : assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> (!mem_valid_reg && !prod_valid_reg))
        else $error("accepting requests with MAC pipeline still busy");

endmodule
